/* hw/rtl/eth_pkg.sv */
// Shared types, constants and the ordering function of the event timeline heap.
// Depends on nothing; event_timeline_heap imports it.
`default_nettype none

package eth_pkg;

  localparam int unsigned MaxEvents = 64;
  localparam int unsigned SlotW     = $clog2(MaxEvents);
  localparam int unsigned CountW    = SlotW + 1;
  localparam int unsigned ChildW    = SlotW + 2;
  localparam int unsigned TimeW     = 24;
  localparam int unsigned PrioW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxEvents);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NO_SLOT = 2'd2
  } status_e;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LAST_CMP,
    ST_DN_CHK,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_HD_RD,
    ST_HD_PL,
    ST_HD_OUT
  } state_e;

  // One heap entry: the sort key travels with the slot number.
  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [PrioW-1:0] prio;
    logic [SlotW-1:0] slot;
  } entry_t;

  // True when a is served no later than b.
  function automatic logic comes_before(entry_t a, entry_t b);
    if (a.ev_time != b.ev_time) begin
      return a.ev_time < b.ev_time;
    end
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return a.slot <= b.slot;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/event_timeline_heap.sv */
// Timed event scheduler: slot pool plus binary min-heap held in synchronous memories.
// Depends on eth_pkg (types, ordering function, state and status codes).
//
// Channel | Direction | Handshake             | Transaction
// in      | sink      | in_valid_i/in_stall_o | one add or delete request
// out     | source    | out_valid_o/out_stall_i | head of queue, count, status
// cfg     | sink      | cfg_valid_i/cfg_ready_o | capacity register write
//
// Sequencing: one request at a time. An add that fits scans the used marks for the
// next free slot, one slot bit a cycle, then sifts the new entry up the heap; a
// delete searches the heap entry by entry (one read of the heap memory port each),
// moves the last entry into the hole and sifts it up or down. The single read port
// of the heap memory sets this pace.
// Reset clears the used marks, the count and the free pointer; memories need no
// clearing. A stalled result holds in the output register while the next request
// is already accepted; that request's result waits until the register frees.
`default_nettype none

module event_timeline_heap (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire                       operation_i,
  input  wire  [eth_pkg::TimeW-1:0] event_time_i,
  input  wire  [eth_pkg::PrioW-1:0] event_priority_i,
  input  wire  [eth_pkg::DataW-1:0] event_data_i,
  input  wire  [eth_pkg::SlotW-1:0] delete_slot_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [eth_pkg::SlotW-1:0] added_slot_o,
  output logic                      head_valid_o,
  output logic [eth_pkg::SlotW-1:0] head_slot_o,
  output logic [eth_pkg::TimeW-1:0] head_time_o,
  output logic [eth_pkg::DataW-1:0] head_data_o,
  output logic [eth_pkg::CountW-1:0] queued_count_o,
  output logic [1:0]                status_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire  [eth_pkg::CountW-1:0] cfg_capacity_i
);
  import eth_pkg::*;

  // Sequencer state and control registers
  state_e state_q, state_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] ffree_q, ffree_d;
  logic [CountW-1:0] nxt_q, nxt_d;
  logic [CountW-1:0] ptr_q, ptr_d;
  logic [CountW-1:0] cap_q;
  logic [MaxEvents-1:0] used_q, used_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic moved_up_q, moved_up_d;
  logic right_ok_q, right_ok_d;
  status_e status_q, status_d;
  logic [SlotW-1:0] added_q, added_d;

  // Latched request payload
  logic op_q;
  logic [TimeW-1:0] in_time_q;
  logic [PrioW-1:0] in_prio_q;
  logic [DataW-1:0] in_data_q;
  logic [SlotW-1:0] del_slot_q;
  entry_t moving_q, moving_d;
  entry_t left_q, left_d;

  // Output register
  logic out_valid_q, out_valid_d;
  logic [SlotW-1:0] out_added_q, out_added_d;
  logic out_hvalid_q, out_hvalid_d;
  logic [SlotW-1:0] out_hslot_q, out_hslot_d;
  logic [TimeW-1:0] out_htime_q, out_htime_d;
  logic [DataW-1:0] out_hdata_q, out_hdata_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic [1:0] out_status_q, out_status_d;

  // Memories: heap of keyed slot numbers, payload pool
  entry_t heap_mem [MaxEvents];
  entry_t heap_rd_q;
  logic [DataW-1:0] pl_mem [MaxEvents];
  logic [DataW-1:0] pl_rd_q;

  logic heap_we, heap_re, pl_we, pl_re;
  logic [SlotW-1:0] heap_waddr, heap_raddr, pl_waddr, pl_raddr;
  entry_t heap_wdata;

  // Derived values
  logic in_accept, out_free;
  logic [CountW-1:0] cap_eff;
  logic add_full, del_bad;
  logic [SlotW-1:0] parent;
  logic [ChildW-1:0] child, child_r;
  logic child_ok, right_ok;
  logic pick_right, up_swap, dn_swap;
  entry_t sel_entry;
  logic [SlotW-1:0] sel_idx;
  logic scan_stop;
  entry_t new_entry;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Clamp capacity: zero acts as one, above pool size acts as pool size
  assign cap_eff = (cap_q == '0) ? CountW'(1) : ((cap_q > MaxCount) ? MaxCount : cap_q);
  assign add_full = (total_q >= cap_eff) || (ffree_q >= cap_eff);
  assign del_bad  = !used_q[del_slot_q];

  assign new_entry = '{ev_time: in_time_q, prio: in_prio_q, slot: ffree_q[SlotW-1:0]};

  assign parent   = (pos_q - SlotW'(1)) >> 1;
  assign child    = {1'b0, pos_q, 1'b0} + ChildW'(1);
  assign child_r  = child + ChildW'(1);
  assign child_ok = child < {1'b0, total_q};
  assign right_ok = child_r < {1'b0, total_q};

  assign up_swap    = comes_before(moving_q, heap_rd_q);
  assign pick_right = right_ok_q && comes_before(heap_rd_q, left_q);
  assign sel_entry  = pick_right ? heap_rd_q : left_q;
  assign sel_idx    = pick_right ? child_r[SlotW-1:0] : child[SlotW-1:0];
  assign dn_swap    = comes_before(sel_entry, moving_q);

  assign scan_stop = (nxt_q == MaxCount) || !used_q[nxt_q[SlotW-1:0]];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (op_q == OP_ADD) begin
          state_d = add_full ? ST_HD_RD : ST_SCAN;
        end else if (del_bad || total_q == CountW'(1)) begin
          state_d = ST_HD_RD;
        end else begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_SCAN: begin
        if (scan_stop) state_d = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        if (pos_q != '0) begin
          state_d = ST_UP_CMP;
        end else if (op_q == OP_DELETE && !moved_up_q) begin
          state_d = ST_DN_CHK;
        end else begin
          state_d = ST_HD_RD;
        end
      end
      ST_UP_CMP: begin
        if (up_swap) begin
          state_d = ST_UP_CHK;
        end else if (op_q == OP_DELETE && !moved_up_q) begin
          state_d = ST_DN_CHK;
        end else begin
          state_d = ST_HD_RD;
        end
      end
      ST_SRCH_RD: begin
        state_d = (ptr_q >= total_q) ? ST_HD_RD : ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        state_d = (heap_rd_q.slot == del_slot_q) ? ST_LAST_CMP : ST_SRCH_RD;
      end
      ST_LAST_CMP: state_d = ST_UP_CHK;
      ST_DN_CHK:   state_d = child_ok ? ST_DN_RIGHT : ST_HD_RD;
      ST_DN_RIGHT: state_d = ST_DN_CMP;
      ST_DN_CMP:   state_d = dn_swap ? ST_DN_CHK : ST_HD_RD;
      ST_HD_RD:    state_d = (total_q == '0) ? ST_HD_OUT : ST_HD_PL;
      ST_HD_PL:    state_d = ST_HD_OUT;
      ST_HD_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    total_d    = total_q;
    ffree_d    = ffree_q;
    nxt_d      = nxt_q;
    ptr_d      = ptr_q;
    used_d     = used_q;
    pos_d      = pos_q;
    moved_up_d = moved_up_q;
    right_ok_d = right_ok_q;
    status_d   = status_q;
    added_d    = added_q;
    moving_d   = moving_q;
    left_d     = left_q;
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = moving_q;
    heap_re    = 1'b0;
    heap_raddr = '0;
    pl_we      = 1'b0;
    pl_waddr   = ffree_q[SlotW-1:0];
    pl_re      = 1'b0;
    pl_raddr   = heap_rd_q.slot;

    out_valid_d  = out_valid_q && out_stall_i;
    out_added_d  = out_added_q;
    out_hvalid_d = out_hvalid_q;
    out_hslot_d  = out_hslot_q;
    out_htime_d  = out_htime_q;
    out_hdata_d  = out_hdata_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;

    case (state_q)
      ST_IDLE: begin
        status_d   = STATUS_OK;
        added_d    = '0;
        moved_up_d = 1'b0;
      end
      ST_DECODE: begin
        if (op_q == OP_ADD) begin
          if (add_full) begin
            status_d = STATUS_FULL;
          end else begin
            pl_we    = 1'b1;
            used_d[ffree_q[SlotW-1:0]] = 1'b1;
            moving_d = new_entry;
            pos_d    = total_q[SlotW-1:0];
            total_d  = total_q + CountW'(1);
            added_d  = ffree_q[SlotW-1:0];
            nxt_d    = ffree_q + CountW'(1);
          end
        end else if (del_bad) begin
          status_d = STATUS_NO_SLOT;
        end else begin
          used_d[del_slot_q] = 1'b0;
          if ({1'b0, del_slot_q} < ffree_q) ffree_d = {1'b0, del_slot_q};
          total_d = total_q - CountW'(1);
          ptr_d   = '0;
        end
      end
      ST_SCAN: begin
        if (scan_stop) begin
          ffree_d = nxt_q;
        end else begin
          nxt_d = nxt_q + CountW'(1);
        end
      end
      ST_UP_CHK: begin
        if (pos_q != '0) begin
          heap_re    = 1'b1;
          heap_raddr = parent;
        end else if (!(op_q == OP_DELETE && !moved_up_q)) begin
          heap_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (up_swap) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd_q;
          pos_d      = parent;
          moved_up_d = 1'b1;
        end else if (!(op_q == OP_DELETE && !moved_up_q)) begin
          heap_we = 1'b1;
        end
      end
      ST_SRCH_RD: begin
        heap_re    = ptr_q < total_q;
        heap_raddr = ptr_q[SlotW-1:0];
      end
      ST_SRCH_CMP: begin
        if (heap_rd_q.slot == del_slot_q) begin
          pos_d      = ptr_q[SlotW-1:0];
          heap_re    = 1'b1;
          heap_raddr = total_q[SlotW-1:0];
        end else begin
          ptr_d = ptr_q + CountW'(1);
        end
      end
      ST_LAST_CMP: begin
        moving_d = heap_rd_q;
      end
      ST_DN_CHK: begin
        if (child_ok) begin
          heap_re    = 1'b1;
          heap_raddr = child[SlotW-1:0];
        end else begin
          heap_we = 1'b1;
        end
      end
      ST_DN_RIGHT: begin
        left_d     = heap_rd_q;
        right_ok_d = right_ok;
        heap_re    = right_ok;
        heap_raddr = child_r[SlotW-1:0];
      end
      ST_DN_CMP: begin
        heap_we = 1'b1;
        if (dn_swap) begin
          heap_wdata = sel_entry;
          pos_d      = sel_idx;
        end
      end
      ST_HD_RD: begin
        heap_re    = total_q != '0;
        heap_raddr = '0;
      end
      ST_HD_PL: begin
        pl_re = 1'b1;
      end
      ST_HD_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_added_d  = added_q;
          out_hvalid_d = total_q != '0;
          out_hslot_d  = (total_q != '0) ? heap_rd_q.slot : '0;
          out_htime_d  = (total_q != '0) ? heap_rd_q.ev_time : '0;
          out_hdata_d  = (total_q != '0) ? pl_rd_q : '0;
          out_count_d  = total_q;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      ffree_q     <= '0;
      used_q      <= '0;
      cap_q       <= MaxCount;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ffree_q     <= ffree_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_capacity_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= operation_i;
      in_time_q  <= event_time_i;
      in_prio_q  <= event_priority_i;
      in_data_q  <= event_data_i;
      del_slot_q <= delete_slot_i;
    end
    nxt_q        <= nxt_d;
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    moved_up_q   <= moved_up_d;
    right_ok_q   <= right_ok_d;
    status_q     <= status_d;
    added_q      <= added_d;
    moving_q     <= moving_d;
    left_q       <= left_d;
    out_added_q  <= out_added_d;
    out_hvalid_q <= out_hvalid_d;
    out_hslot_q  <= out_hslot_d;
    out_htime_q  <= out_htime_d;
    out_hdata_q  <= out_hdata_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  // Heap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (heap_re) heap_rd_q <= heap_mem[heap_raddr];
  end

  // Payload memory
  always_ff @(posedge clk_i) begin
    if (pl_we) pl_mem[pl_waddr] <= in_data_q;
    if (pl_re) pl_rd_q <= pl_mem[pl_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign added_slot_o   = out_added_q;
  assign head_valid_o   = out_hvalid_q;
  assign head_slot_o    = out_hslot_q;
  assign head_time_o    = out_htime_q;
  assign head_data_o    = out_hdata_q;
  assign queued_count_o = out_count_q;
  assign status_o       = out_status_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxCount)
    else $error("queue count above pool size");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start");

  a_ffree_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && ffree_q < MaxCount) |-> !used_q[ffree_q[SlotW-1:0]])
    else $error("free pointer names a used slot");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(used_q) == int'(total_q))
    else $error("used marks disagree with queue count");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_FULL) |-> out_hvalid_q)
    else $error("full status with empty queue");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for event_timeline_heap: random add/delete traffic with bursty input and
// stalled output, checked against an internal heap-order predictor.
// Depends on eth_pkg and event_timeline_heap.
`timescale 1ns / 100ps

module tb_top;
  import eth_pkg::*;

  typedef struct packed {
    logic [SlotW-1:0]  added_slot;
    logic              head_valid;
    logic [SlotW-1:0]  head_slot;
    logic [TimeW-1:0]  head_time;
    logic [DataW-1:0]  head_data;
    logic [CountW-1:0] queued_count;
    logic [1:0]        status;
  } head_report_t;

  // Scheduler predictor plus the queue of expected head reports.
  class head_scoreboard;
    logic [TimeW-1:0] ev_time[MaxEvents];
    logic [PrioW-1:0] ev_prio[MaxEvents];
    logic [DataW-1:0] ev_data[MaxEvents];
    bit               used[MaxEvents];
    int unsigned      order[MaxEvents];
    int unsigned      total, free_slot, cap;
    head_report_t     pending[$];
    int               errors;

    function new();
      total = 0; free_slot = 0; cap = 64; errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function bit earlier(int unsigned a, int unsigned b);
      if (ev_time[a] != ev_time[b]) return ev_time[a] < ev_time[b];
      if (ev_prio[a] != ev_prio[b]) return ev_prio[a] > ev_prio[b];
      return a <= b;
    endfunction

    function void resift(int unsigned pos);
      int unsigned mv, par, ch, lastp;
      bit up;
      up = 0;
      if (total <= 1 || pos >= total) return;
      mv = order[pos];
      while (pos > 0) begin
        par = (pos - 1) >> 1;
        if (!earlier(mv, order[par])) break;
        order[pos] = order[par]; pos = par; up = 1;
      end
      if (!up) begin
        lastp = (total - 2) >> 1;
        while (pos <= lastp) begin
          ch = 2 * pos + 1;
          if (ch >= total) break;
          if (ch + 1 < total && earlier(order[ch+1], order[ch])) ch++;
          if (!earlier(order[ch], mv)) break;
          order[pos] = order[ch]; pos = ch;
        end
      end
      order[pos] = mv;
    endfunction

    function void set_capacity(logic [CountW-1:0] v);
      cap = (v == 0) ? 1 : (v > MaxEvents) ? MaxEvents : int'(v);
    endfunction

    // Note an accepted transaction and predict its report.
    function void note_request(op_e op, logic [TimeW-1:0] t, logic [PrioW-1:0] p,
                               logic [DataW-1:0] d, logic [SlotW-1:0] ds);
      head_report_t r;
      int unsigned s, pos;
      r = '0;
      if (op == OP_ADD) begin
        if (total >= cap || free_slot >= cap) r.status = STATUS_FULL;
        else begin
          s = free_slot;
          ev_time[s] = t; ev_prio[s] = p; ev_data[s] = d; used[s] = 1;
          free_slot = s + 1;
          while (free_slot < MaxEvents && used[free_slot]) free_slot++;
          order[total] = s; total++;
          resift(total - 1);
          r.added_slot = SlotW'(s);
        end
      end else begin
        s = ds;
        if (!used[s]) r.status = STATUS_NO_SLOT;
        else begin
          used[s] = 0;
          if (s < free_slot) free_slot = s;
          total--;
          if (total > 0) begin
            pos = 0;
            while (pos < total && order[pos] != s) pos++;
            if (pos < total) begin
              order[pos] = order[total];
              resift(pos);
            end
          end
        end
      end
      if (total > 0) begin
        r.head_valid = 1; r.head_slot = SlotW'(order[0]);
        r.head_time = ev_time[order[0]]; r.head_data = ev_data[order[0]];
      end
      r.queued_count = CountW'(total);
      pending.push_back(r);
    endfunction

    function void check_report(head_report_t a);
      head_report_t e;
      if (pending.size() == 0) begin
        $error("unexpected report, nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.added_slot !== e.added_slot) begin
        $error("added_slot: expected %0d, actual %0d", e.added_slot, a.added_slot); errors++;
      end
      if (a.head_valid !== e.head_valid) begin
        $error("head_valid: expected %0d, actual %0d", e.head_valid, a.head_valid); errors++;
      end
      if (a.head_slot !== e.head_slot) begin
        $error("head_slot: expected %0d, actual %0d", e.head_slot, a.head_slot); errors++;
      end
      if (a.head_time !== e.head_time) begin
        $error("head_time: expected %0h, actual %0h", e.head_time, a.head_time); errors++;
      end
      if (a.head_data !== e.head_data) begin
        $error("head_data: expected %0h, actual %0h", e.head_data, a.head_data); errors++;
      end
      if (a.queued_count !== e.queued_count) begin
        $error("queued_count: expected %0d, actual %0d", e.queued_count, a.queued_count);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status); errors++;
      end
    endfunction
  endclass

  logic               clk, rst_n;
  logic               in_valid, in_stall, operation;
  logic [TimeW-1:0]   event_time;
  logic [PrioW-1:0]   event_priority;
  logic [DataW-1:0]   event_data;
  logic [SlotW-1:0]   delete_slot;
  logic               out_valid, out_stall;
  logic [SlotW-1:0]   added_slot, head_slot;
  logic               head_valid;
  logic [TimeW-1:0]   head_time;
  logic [DataW-1:0]   head_data;
  logic [CountW-1:0]  queued_count;
  logic [1:0]         status;
  logic               cfg_valid, cfg_ready;
  logic [CountW-1:0]  cfg_capacity;

  head_scoreboard sb;
  int unsigned    cycle_count = 0;
  bit             hold_long;    // request a long receiver hold-off
  bit             sched_bursty; // sender may idle between transactions

  event_timeline_heap dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .event_time_i     (event_time),
    .event_priority_i (event_priority),
    .event_data_i     (event_data),
    .delete_slot_i    (delete_slot),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .added_slot_o     (added_slot),
    .head_valid_o     (head_valid),
    .head_slot_o      (head_slot),
    .head_time_o      (head_time),
    .head_data_o      (head_data),
    .queued_count_o   (queued_count),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_capacity_i   (cfg_capacity)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Bound the run; the worst case is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every report the block hands over.
  always @(posedge clk) begin
    head_report_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.added_slot = added_slot; r.head_valid = head_valid; r.head_slot = head_slot;
      r.head_time = head_time; r.head_data = head_data;
      r.queued_count = queued_count; r.status = status;
      sb.check_report(r);
    end
  end

  // Receiver: stall on its own pattern, mostly open, sometimes heavy, and hold
  // off for a long stretch when asked so the block backs up its input.
  initial begin : receiver
    int unsigned mode, n;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      n = $urandom_range(10, 200);
      repeat (n) begin
        @(posedge clk);
        if (hold_long) begin
          out_stall <= 1'b1;
          repeat (2000) @(posedge clk);
          hold_long = 0;
          out_stall <= 1'b0;
        end else if (mode == 0)
          out_stall <= 1'b0;
        else if (mode == 1)
          out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode == 2)
          out_stall <= ($urandom_range(0, 1) == 0);
        else
          out_stall <= ($urandom_range(0, 9) != 0);
      end
    end
  end

  // Offer one transaction and hold it until accepted.
  task automatic send_request(op_e op, logic [TimeW-1:0] t, logic [PrioW-1:0] p,
                              logic [DataW-1:0] d, logic [SlotW-1:0] ds);
    in_valid <= 1'b1;
    operation <= op;
    event_time <= t;
    event_priority <= p;
    event_data <= d;
    delete_slot <= ds;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, t, p, d, ds);
    if (sched_bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Wait until every report has come, then let the block settle.
  task automatic drain();
    release_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CountW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: time values often clash so priority and slot ties matter.
  task automatic random_request(int unsigned add_weight);
    logic [TimeW-1:0] t;
    logic [SlotW-1:0] ds;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: t = TimeW'($urandom_range(0, 7));
      1: t = {TimeW{1'b1}} - TimeW'($urandom_range(0, 3));
      default: t = TimeW'($urandom);
    endcase
    ds = SlotW'($urandom);
    // Mostly delete slots that are in use.
    if ($urandom_range(0, 9) != 0 && sb.total > 0) begin
      k = $urandom_range(0, sb.total - 1);
      ds = SlotW'(sb.order[k]);
    end
    if ($urandom_range(0, 99) < add_weight)
      send_request(OP_ADD, t, PrioW'($urandom), DataW'($urandom), ds);
    else
      send_request(OP_DELETE, t, PrioW'($urandom), DataW'($urandom), ds);
  endtask

  initial begin : stimulus
    int unsigned i, phase;
    logic [CountW-1:0] caps[6];
    sb = new();
    hold_long = 0;
    sched_bursty = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = OP_ADD;
    event_time = '0;
    event_priority = '0;
    event_data = '0;
    delete_slot = '0;
    cfg_valid = 1'b0;
    cfg_capacity = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: delete on empty, field extremes, ties, full queue.
    send_request(OP_DELETE, '0, '0, '0, '0);
    send_request(OP_ADD, {TimeW{1'b1}}, 4'hF, '1, '1);
    send_request(OP_ADD, '0, '0, '0, '0);
    send_request(OP_ADD, '0, 4'hF, 32'hA5A5_5A5A, '0);
    send_request(OP_ADD, '0, 4'hF, 32'h1234_5678, '0);
    send_request(OP_DELETE, '0, '0, '0, 6'd1);
    send_request(OP_DELETE, '0, '0, '0, 6'd1);
    send_request(OP_DELETE, '0, '0, '0, 6'd63);
    send_request(OP_ADD, 24'd5, 4'd3, 32'h0, '0);
    send_request(OP_DELETE, '0, '0, '0, 6'd2);
    drain();
    write_capacity(7'd0);   // acts as one slot
    send_request(OP_ADD, 24'd9, 4'd1, 32'h1, '0);
    send_request(OP_ADD, 24'd9, 4'd1, 32'h2, '0);
    send_request(OP_DELETE, '0, '0, '0, 6'd0);
    send_request(OP_DELETE, '0, '0, '0, 6'd3);
    drain();
    write_capacity(7'd127); // clamps to the pool size

    caps[0] = 7'd64; caps[1] = 7'd1; caps[2] = 7'd2;
    caps[3] = 7'd100; caps[4] = 7'd17; caps[5] = 7'd64;
    for (phase = 0; phase < 6; phase++) begin
      drain();
      write_capacity(caps[phase]);
      sched_bursty = (phase % 2 == 0);
      if (phase == 3) hold_long = 1;
      for (i = 0; i < 320; i++) begin
        // Fill first, then churn, then empty out.
        if (i < 100) random_request(80);
        else if (i < 250) random_request(50);
        else random_request(20);
        if (phase == 1 && i == 150) drain();
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* event_timeline_heap.f */
hw/rtl/eth_pkg.sv
hw/rtl/event_timeline_heap.sv
test/tb_top.sv
